// ----- hw/rtl/sbf_pkg.sv -----
// ----------------------------------------------------------------------------
// sbf_pkg
// Shared types, constants and the CRC-16 CCITT byte step for the block frame
// receiver.
// ----------------------------------------------------------------------------
package sbf_pkg;

    // Largest number of bytes that one frame may hold before it is closed.
    localparam int MAX_FRAME_BYTES = 4096;
    // The byte counter has to hold MAX_FRAME_BYTES itself.
    localparam int CNT_W = $clog2(MAX_FRAME_BYTES + 1);
    // Width used when the byte count is compared with the 16-bit length.
    localparam int CMP_W = (CNT_W > 16) ? CNT_W : 16;

    localparam int IDX_W   = 12;
    localparam int TDATA_W = 104;
    localparam int TUSER_W = 4;

    // Header byte offsets within a frame.
    localparam logic [3:0] OFS_CRC_LO  = 4'd2;
    localparam logic [3:0] OFS_CRC_HI  = 4'd3;
    localparam logic [3:0] OFS_ID_LO   = 4'd4;
    localparam logic [3:0] OFS_ID_HI   = 4'd5;
    localparam logic [3:0] OFS_LEN_LO  = 4'd6;
    localparam logic [3:0] OFS_LEN_HI  = 4'd7;
    localparam logic [3:0] OFS_TOW_B0  = 4'd8;
    localparam logic [3:0] OFS_TOW_B1  = 4'd9;
    localparam logic [3:0] OFS_TOW_B2  = 4'd10;
    localparam logic [3:0] OFS_TOW_B3  = 4'd11;
    localparam logic [3:0] OFS_WEEK_LO = 4'd12;
    localparam logic [3:0] OFS_WEEK_HI = 4'd13;

    // The CRC covers bytes from this offset on.
    localparam int CRC_START_OFS = 4;
    // A frame can only close on length once more than this many bytes are stored.
    localparam int MIN_STORED_BEFORE_END = 7;
    // Shortest legal declared block length.
    localparam int MIN_BLOCK_LENGTH = 14;
    // Week number meaning "unknown".
    localparam logic [15:0] WEEK_UNKNOWN = 16'hFFFF;

    typedef enum logic [1:0] {
        PH_SYNC1 = 2'd0,
        PH_SYNC2 = 2'd1,
        PH_BODY  = 2'd2
    } sbf_phase_t;

    typedef enum logic [2:0] {
        ST_NONE        = 3'd0,
        ST_TARGET_OK   = 3'd1,
        ST_OTHER_VALID = 3'd2,
        ST_CRC_BAD     = 3'd3,
        ST_LENGTH_BAD  = 3'd4,
        ST_SYNC_LOST   = 3'd5
    } sbf_status_t;

    typedef enum logic [2:0] {
        CFG_FIRST_SYNC  = 3'd0,
        CFG_SECOND_SYNC = 3'd1,
        CFG_TARGET_ID   = 3'd2,
        CFG_TARGET_MIN  = 3'd3,
        CFG_WEEK_MILLIS = 3'd4
    } sbf_cfg_idx_t;

    typedef struct packed {
        logic [7:0]  first_sync;
        logic [7:0]  second_sync;
        logic [12:0] target_block_id;
        logic [15:0] target_min_length;
        logic [31:0] week_millis;
    } sbf_cfg_t;

    typedef struct packed {
        logic [7:0]       byte_value;
        logic [IDX_W-1:0] byte_index;
        logic             in_frame;
        logic             frame_end;
        sbf_status_t      status;
        logic [12:0]      block_id;
        logic [2:0]       block_revision;
        logic [15:0]      block_length;
        logic [31:0]      time_of_week;
        logic [15:0]      week_number;
    } sbf_result_t;

    // One byte of CRC-16 CCITT, polynomial 0x1021, no reflection.
    function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
        logic [7:0] x;
        x = crc[15:8] ^ b;
        x = x ^ (x >> 4);
        return {crc[7:0], 8'h00} ^ {x[3:0], 12'h000} ^ {3'b000, x, 5'b00000} ^ {8'h00, x};
    endfunction

endpackage

// ----- hw/rtl/sbf_frame_core.sv -----
// ----------------------------------------------------------------------------
// sbf_frame_core
// Sync hunt, header capture, running CRC and frame end status for one byte.
// ----------------------------------------------------------------------------
module sbf_frame_core (
    input  logic                clk,
    input  logic                rst_n,
    input  sbf_pkg::sbf_cfg_t   cfg,
    input  logic [7:0]          in_byte,
    input  logic                push,
    output sbf_pkg::sbf_result_t result
);

    sbf_pkg::sbf_phase_t phase_reg, phase_next;
    logic [sbf_pkg::CNT_W-1:0] count_reg, count_next;
    logic [15:0] crc_reg, crc_next;
    logic [15:0] hcrc_reg, hcrc_next;
    logic [15:0] id_reg, id_next;
    logic [15:0] len_reg, len_next;
    logic [31:0] tow_reg, tow_next;
    logic [15:0] week_reg, week_next;

    logic [sbf_pkg::CMP_W-1:0] cnt_ext;
    logic [sbf_pkg::CMP_W-1:0] len_ext;
    logic                      close_frame;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= sbf_pkg::PH_SYNC1;
            count_reg <= '0;
            crc_reg   <= '0;
            hcrc_reg  <= '0;
            id_reg    <= '0;
            len_reg   <= '0;
            tow_reg   <= '0;
            week_reg  <= '0;
        end
        else if (push)
        begin
            phase_reg <= phase_next;
            count_reg <= count_next;
            crc_reg   <= crc_next;
            hcrc_reg  <= hcrc_next;
            id_reg    <= id_next;
            len_reg   <= len_next;
            tow_reg   <= tow_next;
            week_reg  <= week_next;
        end
    end

    always_comb
    begin
        phase_next  = phase_reg;
        count_next  = count_reg;
        crc_next    = crc_reg;
        hcrc_next   = hcrc_reg;
        id_next     = id_reg;
        len_next    = len_reg;
        tow_next    = tow_reg;
        week_next   = week_reg;
        close_frame = 1'b0;
        cnt_ext     = '0;
        len_ext     = '0;

        result            = '0;
        result.byte_value = in_byte;
        result.status     = sbf_pkg::ST_NONE;

        case (phase_reg)
            sbf_pkg::PH_SYNC2:
            begin
                result.byte_index = sbf_pkg::IDX_W'(1);
                if (in_byte == cfg.second_sync)
                begin
                    result.in_frame = 1'b1;
                    count_next      = sbf_pkg::CNT_W'(2);
                    phase_next      = sbf_pkg::PH_BODY;
                end
                else
                begin
                    result.frame_end = 1'b1;
                    result.status    = sbf_pkg::ST_SYNC_LOST;
                    count_next       = '0;
                    phase_next       = sbf_pkg::PH_SYNC1;
                end
            end
            sbf_pkg::PH_BODY:
            begin
                result.byte_index = sbf_pkg::IDX_W'(count_reg);
                result.in_frame   = 1'b1;
                // Header bytes all sit below offset 16.
                if (count_reg[sbf_pkg::CNT_W-1:4] == '0)
                begin
                    case (count_reg[3:0])
                        sbf_pkg::OFS_CRC_LO:  hcrc_next[7:0]   = in_byte;
                        sbf_pkg::OFS_CRC_HI:  hcrc_next[15:8]  = in_byte;
                        sbf_pkg::OFS_ID_LO:   id_next[7:0]     = in_byte;
                        sbf_pkg::OFS_ID_HI:   id_next[15:8]    = in_byte;
                        sbf_pkg::OFS_LEN_LO:  len_next[7:0]    = in_byte;
                        sbf_pkg::OFS_LEN_HI:  len_next[15:8]   = in_byte;
                        sbf_pkg::OFS_TOW_B0:  tow_next[7:0]    = in_byte;
                        sbf_pkg::OFS_TOW_B1:  tow_next[15:8]   = in_byte;
                        sbf_pkg::OFS_TOW_B2:  tow_next[23:16]  = in_byte;
                        sbf_pkg::OFS_TOW_B3:  tow_next[31:24]  = in_byte;
                        sbf_pkg::OFS_WEEK_LO: week_next[7:0]   = in_byte;
                        sbf_pkg::OFS_WEEK_HI: week_next[15:8]  = in_byte;
                        default:              ;
                    endcase
                end
                if (count_reg >= sbf_pkg::CNT_W'(sbf_pkg::CRC_START_OFS))
                begin
                    crc_next = sbf_pkg::crc_step(crc_reg, in_byte);
                end
                count_next = count_reg + sbf_pkg::CNT_W'(1);
                // Stored count including this byte, and the declared length
                // as it stands after this byte.
                cnt_ext = sbf_pkg::CMP_W'(count_next);
                len_ext = sbf_pkg::CMP_W'(len_next);

                close_frame =
                    (cnt_ext > sbf_pkg::CMP_W'(sbf_pkg::MIN_STORED_BEFORE_END) &&
                     cnt_ext >= len_ext) ||
                    (count_next >= sbf_pkg::CNT_W'(sbf_pkg::MAX_FRAME_BYTES));

                if (close_frame)
                begin
                    result.frame_end      = 1'b1;
                    result.block_id       = id_next[12:0];
                    result.block_revision = id_next[15:13];
                    result.block_length   = len_next;
                    result.time_of_week   = tow_next;
                    result.week_number    = week_next;
                    if (len_ext < sbf_pkg::CMP_W'(sbf_pkg::MIN_BLOCK_LENGTH) ||
                        len_ext > cnt_ext)
                    begin
                        result.status = sbf_pkg::ST_LENGTH_BAD;
                    end
                    else if (hcrc_next != crc_next)
                    begin
                        result.status = sbf_pkg::ST_CRC_BAD;
                    end
                    else if (id_next[12:0] == cfg.target_block_id &&
                             len_next >= cfg.target_min_length &&
                             tow_next < cfg.week_millis &&
                             week_next != sbf_pkg::WEEK_UNKNOWN)
                    begin
                        result.status = sbf_pkg::ST_TARGET_OK;
                    end
                    else
                    begin
                        result.status = sbf_pkg::ST_OTHER_VALID;
                    end
                    count_next = '0;
                    phase_next = sbf_pkg::PH_SYNC1;
                end
            end
            default:
            begin
                // Hunting for the first sync byte; an unused phase code lands here too.
                phase_next = sbf_pkg::PH_SYNC1;
                if (in_byte == cfg.first_sync)
                begin
                    result.in_frame = 1'b1;
                    count_next      = sbf_pkg::CNT_W'(1);
                    crc_next        = '0;
                    hcrc_next       = '0;
                    id_next         = '0;
                    len_next        = '0;
                    tow_next        = '0;
                    week_next       = '0;
                    phase_next      = sbf_pkg::PH_SYNC2;
                end
            end
        endcase
    end

`ifndef ASSERT_OFF
    // The counter is cleared on the byte that fills the buffer.
    a_count_below_max: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg < sbf_pkg::CNT_W'(sbf_pkg::MAX_FRAME_BYTES))
        else $error("byte count reached the buffer size");

    // Waiting for the second sync byte means exactly one byte is stored.
    a_sync2_count: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == sbf_pkg::PH_SYNC2 |-> count_reg == sbf_pkg::CNT_W'(1))
        else $error("second sync phase with wrong byte count");

    // Inside a frame body at least the two sync bytes have been stored.
    a_body_count: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == sbf_pkg::PH_BODY |-> count_reg >= sbf_pkg::CNT_W'(2))
        else $error("frame body with fewer than two stored bytes");
`endif

endmodule

// ----- hw/rtl/sbf_out_buf.sv -----
// ----------------------------------------------------------------------------
// sbf_out_buf
// Two-entry output register with skid slot for result words.
// ----------------------------------------------------------------------------
module sbf_out_buf (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  sbf_pkg::sbf_result_t push_data,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    output sbf_pkg::sbf_result_t out_data
);

    logic                 main_valid_reg;
    logic                 skid_valid_reg;
    sbf_pkg::sbf_result_t main_reg;
    sbf_pkg::sbf_result_t skid_reg;
    logic                 pop;

    assign in_ready  = !skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_data  = main_reg;
    assign pop       = main_valid_reg && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!main_valid_reg || pop)
        begin
            if (skid_valid_reg)
            begin
                main_valid_reg <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                main_valid_reg <= push;
            end
        end
        else if (push)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!main_valid_reg || pop)
        begin
            main_reg <= skid_valid_reg ? skid_reg : push_data;
        end
        else if (push)
        begin
            skid_reg <= push_data;
        end
    end

`ifndef ASSERT_OFF
    // The skid slot only fills behind a held word.
    a_skid_behind_main: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> main_valid_reg)
        else $error("skid slot full while output register empty");

    // A held skid word moves forward as soon as the output word leaves.
    a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg && pop |=> main_valid_reg && !skid_valid_reg)
        else $error("skid word not moved into the output register");

    // A push into a stalled full register lands in the skid slot.
    a_push_to_skid: assert property (@(posedge clk) disable iff (!rst_n)
        main_valid_reg && !pop && push |=> skid_valid_reg)
        else $error("word pushed while stalled was dropped");
`endif

endmodule

// ----- hw/rtl/sbf_block_frame_receiver.sv -----
// ----------------------------------------------------------------------------
// sbf_block_frame_receiver
// Block frame receiver: finds the two sync bytes, captures the header, checks
// the CRC-16 CCITT and reports a status on the byte that closes each frame.
// ----------------------------------------------------------------------------
//
// Channel  Direction  Handshake            Payload
// -------  ---------  -------------------  ----------------------------------
// s_*      in         s_tvalid / s_tready  one received byte per word
// m_*      out        m_tvalid / m_tready  echoed byte, index, status, header
// cfg_*    in         cfg_valid/cfg_ready  register index and write data
//
// Every accepted byte produces exactly one output word. The byte is evaluated
// in the cycle it is accepted and its word is registered in the output
// register, or in the skid slot while m_tready is low, before it reaches m_*.
// A byte can be taken every cycle while s_tready is high: one word per clock.
// A two-entry output buffer lets one more byte in while a word is stalled on
// m_tready; s_tready drops only when both entries are full.
// Reset (rst_n low) puts the receiver back to hunting for the first sync byte
// and restores the register defaults. cfg_ready is always high.
//
module sbf_block_frame_receiver (
    input  logic         clk,
    input  logic         rst_n,

    // Input byte stream.
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // [7:0] rx_byte

    // Result stream.
    output logic         m_tvalid,
    input  logic         m_tready,
    // [7:0] byte_value, [19:8] byte_index, [32:20] block_id,
    // [35:33] block_revision, [51:36] block_length, [83:52] time_of_week,
    // [99:84] week_number, [103:100] zero
    output logic [103:0] m_tdata,
    output logic         m_tlast,   // frame_end
    output logic [3:0]   m_tuser,   // [0] in_frame, [3:1] status

    // Register writes.
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [2:0]   cfg_index,
    input  logic [31:0]  cfg_data
);

    sbf_pkg::sbf_cfg_t    cfg_reg;
    sbf_pkg::sbf_result_t core_result;
    sbf_pkg::sbf_result_t out_word;
    logic                 push;

    // Registers can be written at any time; software keeps the stream idle.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.first_sync        <= 8'd36;
            cfg_reg.second_sync       <= 8'd64;
            cfg_reg.target_block_id   <= 13'd4007;
            cfg_reg.target_min_length <= 16'd96;
            cfg_reg.week_millis       <= 32'd604800000;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (sbf_pkg::sbf_cfg_idx_t'(cfg_index))
                sbf_pkg::CFG_FIRST_SYNC:  cfg_reg.first_sync        <= cfg_data[7:0];
                sbf_pkg::CFG_SECOND_SYNC: cfg_reg.second_sync       <= cfg_data[7:0];
                sbf_pkg::CFG_TARGET_ID:   cfg_reg.target_block_id   <= cfg_data[12:0];
                sbf_pkg::CFG_TARGET_MIN:  cfg_reg.target_min_length <= cfg_data[15:0];
                sbf_pkg::CFG_WEEK_MILLIS: cfg_reg.week_millis       <= cfg_data;
                default:                  ;
            endcase
        end
    end

    assign push = s_tvalid && s_tready;

    // Frame state and per-byte result logic.
    sbf_frame_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .in_byte (s_tdata),
        .push    (push),
        .result  (core_result)
    );

    // Result register with skid slot.
    sbf_out_buf u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (core_result),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_word)
    );

    assign m_tdata = {4'b0000,
                      out_word.week_number,
                      out_word.time_of_week,
                      out_word.block_length,
                      out_word.block_revision,
                      out_word.block_id,
                      out_word.byte_index,
                      out_word.byte_value};
    assign m_tlast = out_word.frame_end;
    assign m_tuser = {out_word.status, out_word.in_frame};

`ifndef ASSERT_OFF
    // A frame end always carries a status, and only a frame end does.
    a_end_has_status: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tlast == (m_tuser[3:1] != sbf_pkg::ST_NONE)))
        else $error("frame end and status disagree");

    // Lost sync is reported on a byte that was not stored in a frame.
    a_sync_lost_out_of_frame: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[3:1] == sbf_pkg::ST_SYNC_LOST |-> !m_tuser[0])
        else $error("sync lost reported on a stored byte");

    // Header fields are shown only on a frame end that closes a stored frame.
    a_header_only_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !(m_tlast && m_tuser[0]) |-> m_tdata[103:20] == '0)
        else $error("header fields on a word that does not close a frame");
`endif

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench for the block frame receiver.
// Builds framed byte streams (good target blocks, other blocks, CRC errors,
// bad lengths, broken sync and noise) and runs them through several register
// settings. A bit-accurate frame predictor checks every output word.
// ----------------------------------------------------------------------------
module tb_top;

    import sbf_pkg::*;

    localparam int CYCLE_LIMIT  = 1000000;
    localparam int NUM_PHASES   = 6;
    localparam int PHASE_BUDGET = 100;

    logic         clk;
    logic         rst_n;

    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [7:0]   s_tdata  = 8'h00;

    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [103:0] m_tdata;
    logic         m_tlast;
    logic [3:0]   m_tuser;

    logic         cfg_valid;
    logic         cfg_ready;
    logic [2:0]   cfg_index;
    logic [31:0]  cfg_data;

    sbf_block_frame_receiver DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Bytes waiting to be sent, and the words the predictor says must come out.
    logic [7:0]  rx_pending [$];
    sbf_result_t expected_words [$];

    int mismatches = 0;
    int src_gap    = 0;
    int sink_gap   = 0;

    // When set, both sides insert random idle bursts.
    bit bursty = 1'b1;

    // Our copy of the register file, starting from the reset values.
    sbf_cfg_t cfg_model = '{first_sync: 8'd36, second_sync: 8'd64,
                            target_block_id: 13'd4007, target_min_length: 16'd96,
                            week_millis: 32'd604800000};

    // Predictor state: phase, stored byte count, running CRC and the
    // fourteen header bytes as they arrive (byte 0 in the low bits).
    sbf_phase_t   frame_phase  = PH_SYNC1;
    int           frame_count  = 0;
    logic [15:0]  frame_crc    = 16'h0000;
    logic [111:0] frame_header = '0;

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // CRC-16 CCITT, polynomial 0x1021, MSB first, one bit at a time.
    function automatic logic [15:0] crc16_ccitt(logic [15:0] crc, logic [7:0] b);
        crc = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++)
            crc = crc[15] ? ((crc << 1) ^ 16'h1021) : (crc << 1);
        return crc;
    endfunction

    // Advances the predictor by one accepted byte and returns the word that
    // the receiver has to produce for it.
    function automatic sbf_result_t predict_word(logic [7:0] b);
        sbf_result_t w;
        int          idx;
        logic [15:0] hdr_crc;
        logic [15:0] id_word;
        logic [15:0] length;
        logic [31:0] tow;
        logic [15:0] week;
        w = '0;
        w.byte_value = b;
        w.status = ST_NONE;
        case (frame_phase)
            PH_SYNC2:
            begin
                w.byte_index = IDX_W'(1);
                if (b == cfg_model.second_sync)
                begin
                    w.in_frame  = 1'b1;
                    frame_count = 2;
                    frame_phase = PH_BODY;
                end
                else
                begin
                    // A wrong second byte breaks sync; it is not retried as a
                    // first sync byte.
                    w.frame_end = 1'b1;
                    w.status    = ST_SYNC_LOST;
                    frame_count = 0;
                    frame_phase = PH_SYNC1;
                end
            end
            PH_BODY:
            begin
                idx = frame_count;
                w.byte_index = IDX_W'(idx);
                w.in_frame = 1'b1;
                if (idx < MIN_BLOCK_LENGTH)
                    frame_header[idx*8 +: 8] = b;
                if (idx >= CRC_START_OFS)
                    frame_crc = crc16_ccitt(frame_crc, b);
                frame_count = idx + 1;
                hdr_crc = frame_header[31:16];
                id_word = frame_header[47:32];
                length  = frame_header[63:48];
                tow     = frame_header[95:64];
                week    = frame_header[111:96];
                if ((frame_count > MIN_STORED_BEFORE_END && frame_count >= int'(length))
                    || frame_count >= MAX_FRAME_BYTES)
                begin
                    w.frame_end      = 1'b1;
                    w.block_id       = id_word[12:0];
                    w.block_revision = id_word[15:13];
                    w.block_length   = length;
                    w.time_of_week   = tow;
                    w.week_number    = week;
                    if (length < MIN_BLOCK_LENGTH || int'(length) > frame_count)
                        w.status = ST_LENGTH_BAD;
                    else if (hdr_crc != frame_crc)
                        w.status = ST_CRC_BAD;
                    else if (id_word[12:0] == cfg_model.target_block_id &&
                             length >= cfg_model.target_min_length &&
                             tow < cfg_model.week_millis && week != WEEK_UNKNOWN)
                        w.status = ST_TARGET_OK;
                    else
                        w.status = ST_OTHER_VALID;
                    frame_count = 0;
                    frame_phase = PH_SYNC1;
                end
            end
            default:
            begin
                frame_phase = PH_SYNC1;
                if (b == cfg_model.first_sync)
                begin
                    frame_count  = 1;
                    frame_crc    = 16'h0000;
                    frame_header = '0;
                    w.in_frame   = 1'b1;
                    frame_phase  = PH_SYNC2;
                end
            end
        endcase
        return w;
    endfunction

    // Queues one frame with the given header. The number of bytes sent is
    // where the receiver will close it: eight for very short lengths, the
    // buffer size for oversized ones, the declared length otherwise.
    function automatic int queue_frame(logic [12:0] id, logic [2:0] rev, logic [15:0] length,
                                       logic [31:0] tow, logic [15:0] week, bit corrupt);
        logic [111:0] hdr;
        logic [7:0]   body [$];
        logic [15:0]  crc;
        int           nbytes;
        if (length < 8)
            nbytes = 8;
        else if (length > MAX_FRAME_BYTES)
            nbytes = MAX_FRAME_BYTES;
        else
            nbytes = length;
        hdr = {week, tow, length, rev, id, 16'h0000,
               cfg_model.second_sync, cfg_model.first_sync};
        crc = 16'h0000;
        for (int i = 0; i < nbytes; i++)
        begin
            body.push_back((i < MIN_BLOCK_LENGTH) ? hdr[i*8 +: 8] : 8'($urandom));
            if (i >= CRC_START_OFS)
                crc = crc16_ccitt(crc, body[i]);
        end
        if (corrupt)
            crc ^= 16'($urandom_range(1, 16'hFFFF));
        body[2] = crc[7:0];
        body[3] = crc[15:8];
        foreach (body[i])
            rx_pending.push_back(body[i]);
        return nbytes;
    endfunction

    // Mostly well-formed frames with random content, plus broken ones and noise.
    // Noise bytes are not counted against the budget since they are ignored.
    function automatic void queue_random_traffic(int budget);
        int          used;
        int          kind;
        int          lo;
        int          n;
        logic [7:0]  b;
        logic [12:0] id;
        logic [15:0] length;
        logic [31:0] tow;
        logic [15:0] week;
        used = 0;
        while (used < budget)
        begin
            kind = $urandom_range(0, 99);
            id   = 13'($urandom);
            tow  = $urandom;
            week = 16'($urandom);
            if (kind < 45)
            begin
                // Wanted block; meets every acceptance rule if min length <= 200.
                lo = int'(cfg_model.target_min_length);
                if (lo <= 40)
                    length = 16'(lo + $urandom_range(0, 24));
                else if (lo <= 200)
                    length = 16'(lo + $urandom_range(0, 6));
                else
                    length = 16'($urandom_range(MIN_BLOCK_LENGTH, 40));
                tow  = $urandom_range(0, cfg_model.week_millis - 1);
                week = 16'($urandom_range(0, 16'hFFFE));
                used += queue_frame(cfg_model.target_block_id, 3'($urandom), length,
                                    tow, week, 1'b0);
            end
            else if (kind < 62)
            begin
                // Valid block that misses one or more acceptance rules, or
                // sits right on one of their boundaries.
                if ($urandom_range(0, 1))
                    id = cfg_model.target_block_id;
                length = 16'($urandom_range(MIN_BLOCK_LENGTH, 40));
                if ($urandom_range(0, 3) == 0 && cfg_model.target_min_length > MIN_BLOCK_LENGTH
                    && cfg_model.target_min_length <= 60)
                    length = cfg_model.target_min_length - 16'd1;
                case ($urandom_range(0, 3))
                    0: tow = 32'hFFFF_FFFF;
                    1: tow = cfg_model.week_millis;
                    2: tow = cfg_model.week_millis - 32'd1;
                    default: tow = $urandom;
                endcase
                if ($urandom_range(0, 2) == 0)
                    week = WEEK_UNKNOWN;
                used += queue_frame(id, 3'($urandom), length, tow, week, 1'b0);
            end
            else if (kind < 72)
            begin
                used += queue_frame(cfg_model.target_block_id, 3'($urandom),
                                    16'($urandom_range(MIN_BLOCK_LENGTH, 40)),
                                    tow, week, 1'b1);
            end
            else if (kind < 80)
            begin
                used += queue_frame(id, 3'($urandom), 16'($urandom_range(0, 13)),
                                    tow, week, 1'($urandom_range(0, 1)));
            end
            else if (kind < 90)
            begin
                // First sync followed by anything but the second sync.
                b = 8'($urandom);
                if (b == cfg_model.second_sync)
                    b ^= 8'h01;
                rx_pending.push_back(cfg_model.first_sync);
                rx_pending.push_back(b);
                used += 2;
            end
            else
            begin
                n = $urandom_range(1, 6);
                for (int i = 0; i < n; i++)
                begin
                    b = 8'($urandom);
                    if (b == cfg_model.first_sync)
                        b = ~b;
                    rx_pending.push_back(b);
                end
            end
        end
    endfunction

    // Compares one output field; X or Z on the actual value counts as a mismatch.
    function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            mismatches++;
        end
    endfunction

    // Register write while the receiver is idle. cfg_ready is sampled at the
    // falling edge, so the write lands on the following rising edge.
    task automatic write_reg(sbf_cfg_idx_t idx, logic [31:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        while (!cfg_ready)
            @(negedge clk);
        @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_FIRST_SYNC:  cfg_model.first_sync        = value[7:0];
            CFG_SECOND_SYNC: cfg_model.second_sync       = value[7:0];
            CFG_TARGET_ID:   cfg_model.target_block_id   = value[12:0];
            CFG_TARGET_MIN:  cfg_model.target_min_length = value[15:0];
            CFG_WEEK_MILLIS: cfg_model.week_millis       = value;
            default: ;
        endcase
    endtask

    // Register settings for each phase after the first; the sync and ID registers
    // reach both extremes, and the last phase goes back to the reset values.
    task automatic apply_setting(int p);
        logic [7:0]  s1;
        logic [7:0]  s2;
        logic [12:0] id;
        logic [15:0] min_len;
        logic [31:0] millis;
        case (p)
            1:
            begin
                s1 = 8'hAA; s2 = 8'h55; id = 13'($urandom);
                min_len = 16'd14; millis = 32'hFFFF_FFFF;
            end
            2:
            begin
                s1 = 8'h00; s2 = 8'hFF; id = 13'd0;
                min_len = 16'hFFFF; millis = 32'd1;
            end
            3:
            begin
                s1 = 8'hFF; s2 = 8'h00; id = 13'h1FFF;
                min_len = 16'd14; millis = 32'd604800000;
            end
            4:
            begin
                // Equal sync bytes are allowed and are tried half the time.
                s1 = 8'($urandom);
                s2 = $urandom_range(0, 1) ? s1 : 8'($urandom);
                id = 13'($urandom);
                min_len = 16'($urandom_range(15, 60));
                millis = $urandom_range(1000, 32'hFFFF_FFFF);
            end
            default:
            begin
                s1 = 8'd36; s2 = 8'd64; id = 13'd4007;
                min_len = 16'd96; millis = 32'd604800000;
            end
        endcase
        write_reg(CFG_FIRST_SYNC,  32'(s1));
        write_reg(CFG_SECOND_SYNC, 32'(s2));
        write_reg(CFG_TARGET_ID,   32'(id));
        write_reg(CFG_TARGET_MIN,  32'(min_len));
        write_reg(CFG_WEEK_MILLIS, millis);
    endtask

    // Idle means: nothing left to send, nothing on the input bus, and every
    // expected word has come out.
    task automatic wait_drained();
        do
            @(negedge clk);
        while (!(rx_pending.size() == 0 && !s_tvalid && expected_words.size() == 0));
    endtask

    // Input driver. A byte is predicted at the edge where it is accepted, and
    // the next byte (or an idle burst) is set up at that same edge so valid
    // only ever gets one assignment per edge.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                expected_words.push_back(predict_word(s_tdata));
            if (!s_tvalid || s_tready)
            begin
                if (src_gap > 0)
                begin
                    src_gap--;
                    s_tvalid <= 1'b0;
                end
                else if (rx_pending.size() > 0)
                begin
                    s_tdata  <= rx_pending.pop_front();
                    s_tvalid <= 1'b1;
                    if (bursty && $urandom_range(0, 7) == 0)
                        src_gap = $urandom_range(1, 15);
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Output monitor. Each accepted word is unpacked and compared with the
    // oldest prediction. tdata holds byte, index and header fields from the
    // low bits up; tuser holds in_frame and the status; tlast is frame_end.
    always @(posedge clk)
    begin : sink_side
        sbf_result_t want;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_words.size() == 0)
                begin
                    $display("%0t: unexpected word, expected none, actual tdata %0h tuser %0h",
                             $time, m_tdata, m_tuser);
                    mismatches++;
                end
                else
                begin
                    want = expected_words.pop_front();
                    check_field("byte_value",     64'(want.byte_value),
                                64'(m_tdata[7:0]));
                    check_field("byte_index",     64'(want.byte_index),
                                64'(m_tdata[19:8]));
                    check_field("block_id",       64'(want.block_id),
                                64'(m_tdata[32:20]));
                    check_field("block_revision", 64'(want.block_revision),
                                64'(m_tdata[35:33]));
                    check_field("block_length",   64'(want.block_length),
                                64'(m_tdata[51:36]));
                    check_field("time_of_week",   64'(want.time_of_week),
                                64'(m_tdata[83:52]));
                    check_field("week_number",    64'(want.week_number),
                                64'(m_tdata[99:84]));
                    check_field("in_frame",       64'(want.in_frame),
                                64'(m_tuser[0]));
                    check_field("status",         64'(want.status),
                                64'(m_tuser[3:1]));
                    check_field("frame_end",      64'(want.frame_end),
                                64'(m_tlast));
                end
            end
            // Random back-pressure bursts while bursty is set.
            if (sink_gap > 0)
            begin
                sink_gap--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
                if (bursty && $urandom_range(0, 11) == 0)
                    sink_gap = $urandom_range(1, 15);
            end
        end
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge clk)
    begin : watchdog
        int cycles;
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    initial
    begin
        int unused;
        rst_n     <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= CFG_FIRST_SYNC;
        cfg_data  <= 32'h0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part at the reset register values: the two byte extremes
        // while hunting, a first sync followed by a wrong second byte, and a
        // frame whose length is too short, so it closes at eight bytes before
        // time of week and week number have been received.
        rx_pending.push_back(8'h00);
        rx_pending.push_back(8'hFF);
        rx_pending.push_back(cfg_model.first_sync);
        rx_pending.push_back(cfg_model.second_sync ^ 8'h01);
        unused = queue_frame(13'd4007, 3'd7, 16'd5, 32'hFFFF_FFFF, WEEK_UNKNOWN, 1'b0);

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            // Registers only change once the previous phase has fully drained.
            wait_drained();
            if (p > 0)
                apply_setting(p);
            // No idling in phase 2 or the last phase; the others use idle bursts.
            bursty = (p != NUM_PHASES - 1) && (p != 2);
            if (p == 1)
            begin
                // Shortest legal wanted block, accepted with the smallest
                // minimum length.
                unused = queue_frame(cfg_model.target_block_id, 3'd0, 16'd14,
                                     32'd0, 16'd0, 1'b0);
            end
            queue_random_traffic(PHASE_BUDGET);
        end

        wait_drained();
        // Keep watching the output to catch any stray extra word.
        repeat (10) @(negedge clk);
        if (mismatches == 0 && expected_words.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
